// ===== sv/spath_pkg.sv =====
// shared types, codes and constants of the shortest path search block
`default_nettype none
package spath_pkg;

    localparam int MAX_NODES    = 64;
    localparam int NODE_BITS    = 6;
    localparam int NCNT_BITS    = 7;
    localparam int DIST_BITS    = 22;
    localparam int WEIGHT_FIELD = 16;
    localparam int DEF_MAX_EDGES   = 256;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [NCNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNREACH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;

    localparam logic [1:0] DA_SEL = 2'd0;
    localparam logic [1:0] DA_V   = 2'd1;
    localparam logic [1:0] DA_DST = 2'd2;

    typedef struct packed {
        logic [1:0]              command;
        logic [NODE_BITS-1:0]    edge_from;
        logic [NODE_BITS-1:0]    edge_to;
        logic [WEIGHT_FIELD-1:0] edge_weight;
        logic [NODE_BITS-1:0]    source_node;
        logic [NODE_BITS-1:0]    dest_node;
    } in_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] path_node;
        logic [DIST_BITS-1:0] total_distance;
        logic                 last;
        logic [1:0]           status;
    } out_t;

    typedef struct packed {
        logic       capture;
        logic       clear_edges;
        logic       add_edge;
        logic       q_init;
        logic       sel_init;
        logic       sel_cmp;
        logic       sel_next;
        logic       settle;
        logic       scan_latch;
        logic       scan_upd;
        logic       scan_next;
        logic       walk_init;
        logic       tot_cap;
        logic       walk_step;
        logic       walk_load;
        logic       emit_out;
        logic       res_status;
        logic [1:0] status_code;
        logic [1:0] dsel;
    } ctl_t;

    typedef struct packed {
        logic [1:0] command;
        logic       bad_edge;
        logic       bad_query;
        logic       full;
        logic       sel_last;
        logic       found;
        logic       scan_empty;
        logic       scan_last;
        logic       dst_reached;
        logic       walk_stop;
        logic       emit_last;
    } sts_t;

endpackage
`default_nettype wire

// ===== sv/spath_dp.sv =====
// datapath: edge store, per-node tables, selection, relaxation and path walk
`default_nettype none
module spath_dp
    import spath_pkg::*;
#(
    parameter int MAX_EDGES   = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire in_t                  request,
    input  wire logic [NCNT_BITS-1:0] node_count,
    input  wire ctl_t                 ctl,
    output sts_t                      sts,
    output logic                      result_valid,
    output out_t                      result
);

    localparam int EAB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECB = $clog2(MAX_EDGES + 1);
    localparam int WB  = WEIGHT_BITS;
    localparam int WX  = (WB > WEIGHT_FIELD) ? WB : WEIGHT_FIELD;
    localparam int DB  = WB + NODE_BITS;
    localparam int DX  = (DB > DIST_BITS) ? DB : DIST_BITS;
    localparam int EB  = 2 * NODE_BITS + WB;

    in_t                   req_reg;
    logic [NCNT_BITS-1:0]  n_use;

    logic [EB-1:0]         edge_mem [MAX_EDGES];
    logic [EB-1:0]         edge_rd_reg;
    logic [ECB-1:0]        edge_total_reg;
    logic [EAB-1:0]        scan_idx_reg;

    logic [DB-1:0]         dist_mem [MAX_NODES];
    logic [DB-1:0]         dist_rd_reg;
    logic [NODE_BITS-1:0]  dist_ra;
    logic [NODE_BITS-1:0]  parent_mem [MAX_NODES];
    logic [NODE_BITS-1:0]  parent_rd_reg;
    logic [NODE_BITS-1:0]  walk_mem [MAX_NODES];
    logic [NODE_BITS-1:0]  walk_rd_reg;
    logic [MAX_NODES-1:0]  reached_reg;
    logic [MAX_NODES-1:0]  settled_reg;

    logic [NODE_BITS-1:0]  sel_idx_reg;
    logic                  found_reg;
    logic [NODE_BITS-1:0]  u_reg;
    logic [DB-1:0]         du_reg;

    logic [NODE_BITS-1:0]  v_reg;
    logic                  hit_reg;
    logic [WB-1:0]         w_reg;

    logic [NODE_BITS-1:0]  node_reg;
    logic [NCNT_BITS-1:0]  len_reg;
    logic [NODE_BITS-1:0]  emit_idx_reg;
    logic [DB-1:0]         tot_reg;

    logic                  result_valid_reg;
    out_t                  result_reg;
    out_t                  result_next;

    logic [WX-1:0]         w_ext;
    logic [WB-1:0]         w_in;
    logic [NODE_BITS-1:0]  ea;
    logic [NODE_BITS-1:0]  eb;
    logic [WB-1:0]         ew;
    logic                  e_ok;
    logic                  hit;
    logic [NODE_BITS-1:0]  v;
    logic [DB-1:0]         nd;
    logic                  improve;
    logic                  cand;
    logic [DX-1:0]         tot_x;
    logic [DIST_BITS-1:0]  tot_sat;

    assign n_use = (node_count > NCNT_BITS'(MAX_NODES)) ? NCNT_BITS'(MAX_NODES) : node_count;

    assign w_ext = WX'(req_reg.edge_weight);
    assign w_in  = w_ext[WB-1:0];

    assign ea   = edge_rd_reg[EB-1 -: NODE_BITS];
    assign eb   = edge_rd_reg[EB-NODE_BITS-1 -: NODE_BITS];
    assign ew   = edge_rd_reg[WB-1:0];
    assign e_ok = ({1'b0, ea} < n_use) && ({1'b0, eb} < n_use);
    assign hit  = e_ok && ((ea == u_reg) || (eb == u_reg));
    assign v    = (ea == u_reg) ? eb : ea;

    assign nd      = du_reg + DB'(w_reg);
    assign improve = hit_reg && !settled_reg[v_reg]
                     && (!reached_reg[v_reg] || (nd < dist_rd_reg));
    assign cand    = reached_reg[sel_idx_reg] && !settled_reg[sel_idx_reg]
                     && (!found_reg || (dist_rd_reg < du_reg));

    always_comb
    begin
        case (ctl.dsel)
            DA_SEL:  dist_ra = sel_idx_reg;
            DA_V:    dist_ra = v;
            DA_DST:  dist_ra = req_reg.dest_node;
            default: dist_ra = sel_idx_reg;
        endcase
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= request;
        end
    end

    // edge store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
        end
        else if (ctl.clear_edges)
        begin
            edge_total_reg <= '0;
        end
        else if (ctl.add_edge)
        begin
            edge_total_reg <= edge_total_reg + ECB'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.add_edge)
        begin
            edge_mem[edge_total_reg[EAB-1:0]] <= {req_reg.edge_from, req_reg.edge_to, w_in};
        end
        edge_rd_reg <= edge_mem[scan_idx_reg];
    end

    // per-node tables
    always_ff @(posedge clk)
    begin
        if (ctl.q_init)
        begin
            dist_mem[req_reg.source_node]   <= '0;
            parent_mem[req_reg.source_node] <= req_reg.source_node;
        end
        else if (ctl.scan_upd && improve)
        begin
            dist_mem[v_reg]   <= nd;
            parent_mem[v_reg] <= u_reg;
        end
        dist_rd_reg   <= dist_mem[dist_ra];
        parent_rd_reg <= parent_mem[node_reg];
        if (ctl.walk_step)
        begin
            walk_mem[len_reg[NODE_BITS-1:0]] <= node_reg;
        end
        walk_rd_reg <= walk_mem[emit_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.q_init)
        begin
            reached_reg <= MAX_NODES'(1) << req_reg.source_node;
            settled_reg <= '0;
        end
        else
        begin
            if (ctl.scan_upd && improve)
            begin
                reached_reg[v_reg] <= 1'b1;
            end
            if (ctl.settle)
            begin
                settled_reg[u_reg] <= 1'b1;
            end
        end
    end

    // selection and relaxation
    always_ff @(posedge clk)
    begin
        if (ctl.sel_init)
        begin
            sel_idx_reg <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.sel_cmp && cand)
            begin
                u_reg     <= sel_idx_reg;
                du_reg    <= dist_rd_reg;
                found_reg <= 1'b1;
            end
            if (ctl.sel_next)
            begin
                sel_idx_reg <= sel_idx_reg + NODE_BITS'(1);
            end
        end
        if (ctl.settle)
        begin
            scan_idx_reg <= '0;
        end
        else if (ctl.scan_next)
        begin
            scan_idx_reg <= scan_idx_reg + EAB'(1);
        end
        if (ctl.scan_latch)
        begin
            v_reg   <= v;
            hit_reg <= hit;
            w_reg   <= ew;
        end
    end

    // path walk back from the destination
    always_ff @(posedge clk)
    begin
        if (ctl.walk_init)
        begin
            node_reg <= req_reg.dest_node;
            len_reg  <= '0;
        end
        else if (ctl.walk_load)
        begin
            node_reg <= parent_rd_reg;
        end
        else if (ctl.walk_step)
        begin
            len_reg      <= len_reg + NCNT_BITS'(1);
            emit_idx_reg <= len_reg[NODE_BITS-1:0];
        end
        else if (ctl.emit_out)
        begin
            emit_idx_reg <= emit_idx_reg - NODE_BITS'(1);
        end
        if (ctl.tot_cap)
        begin
            tot_reg <= dist_rd_reg;
        end
    end

    // result register
    assign tot_x   = DX'(tot_reg);
    assign tot_sat = (tot_x > DX'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(tot_x);

    always_comb
    begin
        result_next = result_reg;
        if (ctl.res_status)
        begin
            result_next.path_node      = '0;
            result_next.total_distance = '0;
            result_next.last           = 1'b1;
            result_next.status         = ctl.status_code;
        end
        else if (ctl.emit_out)
        begin
            result_next.path_node      = walk_rd_reg;
            result_next.total_distance = tot_sat;
            result_next.last           = (emit_idx_reg == '0);
            result_next.status         = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctl.res_status | ctl.emit_out;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // status to the controller
    assign sts.command     = req_reg.command;
    assign sts.bad_edge    = ({1'b0, req_reg.edge_from} >= n_use)
                             || ({1'b0, req_reg.edge_to} >= n_use);
    assign sts.bad_query   = ({1'b0, req_reg.source_node} >= n_use)
                             || ({1'b0, req_reg.dest_node} >= n_use);
    assign sts.full        = (edge_total_reg == ECB'(MAX_EDGES));
    assign sts.sel_last    = ({1'b0, sel_idx_reg} == (n_use - NCNT_BITS'(1)));
    assign sts.found       = found_reg;
    assign sts.scan_empty  = (edge_total_reg == '0);
    assign sts.scan_last   = ((ECB'(scan_idx_reg) + ECB'(1)) == edge_total_reg);
    assign sts.dst_reached = reached_reg[req_reg.dest_node];
    assign sts.walk_stop   = (node_reg == req_reg.source_node)
                             || ((len_reg + NCNT_BITS'(1)) == n_use);
    assign sts.emit_last   = (emit_idx_reg == '0);

endmodule
`default_nettype wire

// ===== sv/spath_ctrl.sv =====
// controller state machine sequencing commands and the search
`default_nettype none
module spath_ctrl
    import spath_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire sts_t sts,
    output ctl_t      ctl,
    output logic      busy
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_SEL_RD    = 4'd2;
    localparam logic [3:0] S_SEL_CMP   = 4'd3;
    localparam logic [3:0] S_SEL_END   = 4'd4;
    localparam logic [3:0] S_SCAN_RD   = 4'd5;
    localparam logic [3:0] S_SCAN_NODE = 4'd6;
    localparam logic [3:0] S_SCAN_UPD  = 4'd7;
    localparam logic [3:0] S_WALK_INIT = 4'd8;
    localparam logic [3:0] S_WALK_TOT  = 4'd9;
    localparam logic [3:0] S_WALK_STEP = 4'd10;
    localparam logic [3:0] S_WALK_WAIT = 4'd11;
    localparam logic [3:0] S_EMIT_RD   = 4'd12;
    localparam logic [3:0] S_EMIT_OUT  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.dsel   = DA_SEL;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (sts.command)
                    CMD_CLEAR:
                    begin
                        ctl.clear_edges = 1'b1;
                    end
                    CMD_ADD:
                    begin
                        ctl.res_status = 1'b1;
                        if (sts.bad_edge)
                        begin
                            ctl.status_code = ST_RANGE;
                        end
                        else if (sts.full)
                        begin
                            ctl.status_code = ST_FULL;
                        end
                        else
                        begin
                            ctl.add_edge    = 1'b1;
                            ctl.status_code = ST_OK;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (sts.bad_query)
                        begin
                            ctl.res_status  = 1'b1;
                            ctl.status_code = ST_RANGE;
                        end
                        else
                        begin
                            ctl.q_init   = 1'b1;
                            ctl.sel_init = 1'b1;
                            state_next   = S_SEL_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEL_RD:
            begin
                state_next = S_SEL_CMP;
            end
            S_SEL_CMP:
            begin
                ctl.sel_cmp = 1'b1;
                if (sts.sel_last)
                begin
                    state_next = S_SEL_END;
                end
                else
                begin
                    ctl.sel_next = 1'b1;
                    state_next   = S_SEL_RD;
                end
            end
            S_SEL_END:
            begin
                if (sts.found)
                begin
                    ctl.settle = 1'b1;
                    if (sts.scan_empty)
                    begin
                        ctl.sel_init = 1'b1;
                        state_next   = S_SEL_RD;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = S_WALK_INIT;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_NODE;
            end
            S_SCAN_NODE:
            begin
                ctl.scan_latch = 1'b1;
                ctl.dsel       = DA_V;
                state_next     = S_SCAN_UPD;
            end
            S_SCAN_UPD:
            begin
                ctl.scan_upd = 1'b1;
                if (sts.scan_last)
                begin
                    ctl.sel_init = 1'b1;
                    state_next   = S_SEL_RD;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_WALK_INIT:
            begin
                ctl.dsel = DA_DST;
                if (!sts.dst_reached)
                begin
                    ctl.res_status  = 1'b1;
                    ctl.status_code = ST_UNREACH;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ctl.walk_init = 1'b1;
                    state_next    = S_WALK_TOT;
                end
            end
            S_WALK_TOT:
            begin
                ctl.tot_cap = 1'b1;
                state_next  = S_WALK_STEP;
            end
            S_WALK_STEP:
            begin
                ctl.walk_step = 1'b1;
                state_next    = sts.walk_stop ? S_EMIT_RD : S_WALK_WAIT;
            end
            S_WALK_WAIT:
            begin
                ctl.walk_load = 1'b1;
                state_next    = S_WALK_STEP;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                ctl.emit_out = 1'b1;
                state_next   = sts.emit_last ? S_IDLE : S_EMIT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ===== sv/shortest_path_search_top.sv =====
// top level of the shortest path search block with its register port
// clear and add edge finish in the decode state; an add edge status result comes in the same cycle busy falls
// query: its length is set by the node scan and edge scan over single-port tables
// one request at a time; results cannot be stalled
// reset clears the controller, the edge count and node_count (to 64); no clearing pass
`default_nettype none
module shortest_path_search_top
    import spath_pkg::*;
#(
    parameter int MAX_EDGES   = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire in_t         request,
    output logic             result_valid,
    output out_t             result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [NCNT_BITS-1:0] node_count_reg;
    logic                 cfg_wr;
    ctl_t                 ctl;
    sts_t                 sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_NODE_COUNT);
    assign prdata = (paddr == ADDR_NODE_COUNT) ? 32'(node_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            node_count_reg <= pwdata[NCNT_BITS-1:0];
        end
    end

    spath_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    spath_dp #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .node_count   (node_count_reg),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != ST_OK))
            |-> (result.last && (result.path_node == '0) && (result.total_distance == '0)))
        else $error("error status result carries path data");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (node_count_reg == $past(pwdata[NCNT_BITS-1:0])))
        else $error("node_count write lost");
`endif

endmodule
`default_nettype wire
